// ===== hw/rtl/mandelbrot_escape_iterations_top_assert.svh =====
// Assertion macros for the top-level RTL.
`ifndef MANDELBROT_ESCAPE_ITERATIONS_TOP_ASSERT_SVH
`define MANDELBROT_ESCAPE_ITERATIONS_TOP_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define MANDEL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define MANDEL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mandel_pkg.sv =====
package mandel_pkg;

    localparam int unsigned MAX_DIM  = 4096;
    localparam int unsigned MAX_ITER = 4096;
    localparam int unsigned FRAC_W   = 28;

    localparam int unsigned COORD_W  = 12;
    localparam int unsigned CNT_W    = 13;
    localparam int unsigned Q_W      = 32;
    localparam int unsigned STEP_W   = 31;
    localparam int unsigned C_W      = 45;
    localparam int unsigned NZ_W     = 46;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned S_DATA_W = 24;
    localparam int unsigned M_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_REAL_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAG_ORIGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REAL_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAG_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT  = 3'd4;

    typedef struct packed {
        logic [COORD_W-1:0]  column;
        logic [COORD_W-1:0]  row;
        logic signed [C_W-1:0] c_real;
        logic signed [C_W-1:0] c_imag;
        logic [CNT_W-1:0]    limit;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

// ===== hw/rtl/mandel_front.sv =====
module mandel_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mandel_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mandel_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [31:0]                         cfg_data,
    output logic                                job_valid,
    input  logic                                job_ready,
    output mandel_pkg::job_t                    job
);
    import mandel_pkg::*;

    localparam logic [COORD_W-1:0] DIM_MASK = COORD_W'(MAX_DIM - 1);

    logic signed [Q_W-1:0]  real_origin_reg;
    logic signed [Q_W-1:0]  imag_origin_reg;
    logic [STEP_W-1:0]      real_step_reg;
    logic [STEP_W-1:0]      imag_step_reg;
    logic [CNT_W-1:0]       iter_limit_reg;

    logic                   valid_reg, valid_next;
    job_t                   job_reg, job_next;
    logic                   accept;

    logic [COORD_W-1:0]     col_m, row_m;
    logic [42:0]            prod_r, prod_i;
    logic [CNT_W-1:0]       limit_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            real_origin_reg <= -32'sd536870912;
            imag_origin_reg <= -32'sd536870912;
            real_step_reg   <= 31'd262144;
            imag_step_reg   <= 31'd262144;
            iter_limit_reg  <= 13'd256;
        end else if (cfg_valid) begin
            case (cfg_addr)
                CFG_REAL_ORIGIN: real_origin_reg <= $signed(cfg_data);
                CFG_IMAG_ORIGIN: imag_origin_reg <= $signed(cfg_data);
                CFG_REAL_STEP:   real_step_reg   <= cfg_data[STEP_W-1:0];
                CFG_IMAG_STEP:   imag_step_reg   <= cfg_data[STEP_W-1:0];
                CFG_ITER_LIMIT:  iter_limit_reg  <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready  = !valid_reg || job_ready;
    assign accept    = s_tvalid && s_tready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    // Map pixel to point, clamp limit to [1, MAX_ITER]
    always_comb begin
        col_m  = s_tdata[COORD_W-1:0] & DIM_MASK;
        row_m  = s_tdata[2*COORD_W-1:COORD_W] & DIM_MASK;
        prod_r = 43'(col_m) * 43'(real_step_reg);
        prod_i = 43'(row_m) * 43'(imag_step_reg);
        if (iter_limit_reg == '0) begin
            limit_eff = CNT_W'(1);
        end else if (iter_limit_reg > CNT_W'(MAX_ITER)) begin
            limit_eff = CNT_W'(MAX_ITER);
        end else begin
            limit_eff = iter_limit_reg;
        end
        job_next        = job_reg;
        job_next.column = col_m;
        job_next.row    = row_m;
        job_next.c_real = C_W'(real_origin_reg) + $signed({2'b00, prod_r});
        job_next.c_imag = C_W'(imag_origin_reg) + $signed({2'b00, prod_i});
        job_next.limit  = limit_eff;
        valid_next      = accept || (valid_reg && !job_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            job_reg <= job_next;
        end
    end

endmodule

// ===== hw/rtl/mandel_fifo.sv =====
module mandel_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  mandel_pkg::job_t        push_job,
    input  logic                    pop,
    output mandel_pkg::job_t        pop_job,
    output mandel_pkg::fifo_stat_t  stat
);
    import mandel_pkg::*;

    job_t        slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
        stat.full   = count_reg == 2'd2;
        stat.empty  = count_reg == 2'd0;
        pop_job     = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hw/rtl/mandel_core.sv =====
module mandel_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                job_avail,
    output logic                                job_pop,
    input  mandel_pkg::job_t                    job,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mandel_pkg::M_DATA_W-1:0]     m_tdata
);
    import mandel_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]             state_reg, state_next;
    job_t                   job_reg;
    logic signed [Q_W-1:0]  zr_reg, zi_reg, zr_next, zi_next;
    logic [63:0]            rr_reg, ii_reg;
    logic signed [63:0]     ri_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0]    out_data_reg;
    logic                   out_load;

    logic [63:0]            mag;
    logic signed [63:0]     diff;
    logic signed [NZ_W-1:0] nr, ni;
    logic                   ovf;
    logic                   stop;

    always_comb begin
        mag  = rr_reg + ii_reg;
        diff = $signed(rr_reg) - $signed(ii_reg);
        nr   = NZ_W'(diff >>> FRAC_W) + NZ_W'(job_reg.c_real);
        ni   = NZ_W'(ri_reg >>> (FRAC_W - 1)) + NZ_W'(job_reg.c_imag);
        ovf  = (nr[NZ_W-1:Q_W-1] != '0 && nr[NZ_W-1:Q_W-1] != '1) ||
               (ni[NZ_W-1:Q_W-1] != '0 && ni[NZ_W-1:Q_W-1] != '1);
        // Stop once counted: |z|^2 >= 4.0 in Q8.56, or count at the limit
        stop = (count_reg != '0) &&
               ((mag[63:58] != '0) || (count_reg >= job_reg.limit));
    end

    assign job_pop  = (state_reg == ST_IDLE) && job_avail;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        count_next = count_reg;
        case (state_reg)
            ST_IDLE: begin
                if (job_avail) begin
                    zr_next    = '0;
                    zi_next    = '0;
                    count_next = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (stop) begin
                    state_next = ST_DONE;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    if (ovf) begin
                        state_next = ST_DONE;
                    end else begin
                        zr_next    = nr[Q_W-1:0];
                        zi_next    = ni[Q_W-1:0];
                        state_next = ST_MUL;
                    end
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        out_valid_next = out_load || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        zr_reg    <= zr_next;
        zi_reg    <= zi_next;
        count_reg <= count_next;
        if (job_pop) begin
            job_reg <= job;
        end
        if (state_reg == ST_MUL) begin
            rr_reg <= zr_reg * zr_reg;
            ii_reg <= zi_reg * zi_reg;
            ri_reg <= zr_reg * zi_reg;
        end
        if (out_load) begin
            out_data_reg <= {3'b000, job_reg.row, job_reg.column, count_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== hw/rtl/mandelbrot_escape_iterations_top.sv =====
// Mandelbrot escape-time counter, signed Q4.28 fixed point.
// Input stream s_*: one word per pixel, column and row. The point c is
// real_origin + column*real_step, imag_origin + row*imag_step; z = z^2 + c
// runs from zero until |z|^2 reaches 4.0, a component leaves Q4.28, or the
// count reaches iteration_limit (0 acts as 1, clamped to 4096).
// Output stream m_*: one word per pixel, count and echoed coordinates,
// in input order.
// Config channel cfg_*: index 0..4 = real_origin, imag_origin, real_step,
// imag_step, iteration_limit; always ready; write only while idle.
// A pixel passes the input register and the job queue into the iteration
// engine, which alternates a product state (three 32x32 products) and an
// update state (new z, escape test); the magnitude test of the last
// iteration takes one more pair, unless the pixel ends on a component
// leaving Q4.28, and each pixel adds an idle and a done state. The engine
// takes a new pixel only once it is through with the last one; meanwhile
// the input stage and a 2-entry job queue keep accepting.
// Reset (aresetn low, synchronous) empties all stages and loads register
// defaults. A stall on m_tready holds the output word; the engine then
// parks on its finished pixel and the queue fills before s_tready drops.
module mandelbrot_escape_iterations_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mandel_pkg::S_DATA_W-1:0]     s_tdata,   // column, row
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mandel_pkg::M_DATA_W-1:0]     m_tdata,   // iterations, out_column, out_row
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mandel_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [31:0]                         cfg_data
);
    import mandel_pkg::*;

    `include "mandelbrot_escape_iterations_top_assert.svh"

    logic       job_valid;
    job_t       front_job, queue_job;
    fifo_stat_t q_stat;
    logic       q_push, q_pop;

    assign q_push = job_valid && !q_stat.full;

    mandel_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .job_valid (job_valid),
        .job_ready (!q_stat.full),
        .job       (front_job)
    );

    mandel_fifo u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (front_job),
        .pop      (q_pop),
        .pop_job  (queue_job),
        .stat     (q_stat)
    );

    mandel_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_avail (!q_stat.empty),
        .job_pop   (q_pop),
        .job       (queue_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    `MANDEL_ASSERT_NOW(a_pop_nonempty, q_pop, !q_stat.empty, "pop from empty queue")
    `MANDEL_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_stat.empty, "queue lost a word")
    `MANDEL_ASSERT_NOW(a_count_nonzero, m_tvalid, m_tdata[CNT_W-1:0] != '0, "zero count")
    `MANDEL_ASSERT_NOW(a_count_max, m_tvalid, m_tdata[CNT_W-1:0] <= CNT_W'(MAX_ITER), "count too large")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import mandel_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam longint Q_LO = -64'sd2147483648;
    localparam longint Q_HI = 64'sd2147483647;
    localparam logic [63:0] FOUR_WIDE = 64'h0400_0000_0000_0000;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic {ENTRY_PIXEL, ENTRY_WRITE} entry_kind_t;

    typedef struct {
        entry_kind_t            kind;
        logic [CFG_IDX_W-1:0]   addr;
        logic [31:0]            data;
        logic [COORD_W-1:0]     pix_col;
        logic [COORD_W-1:0]     pix_row;
        bit                     typed;
        logic [CNT_W-1:0]       want;
    } plan_entry_t;

    typedef struct {
        logic [CNT_W-1:0]   iterations;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } pixel_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_addr;
    logic [31:0]            cfg_data;

    longint                 view_real_origin;
    longint                 view_imag_origin;
    longint                 view_real_step;
    longint                 view_imag_step;
    logic [CNT_W-1:0]       view_iter_limit;

    pixel_result_t          pending_pixels[$];
    plan_entry_t            directed_plan[$];
    int                     mismatch_count = 0;
    int                     src_idle = 15;
    int                     sink_idle = 59;
    bit                     hold_outputs = 0;

    mandelbrot_escape_iterations_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [CNT_W-1:0] escape_count(input logic [COORD_W-1:0] col,
                                                      input logic [COORD_W-1:0] row);
        longint      cr, ci, zr, zi, nr, ni;
        logic [63:0] mag;
        int          lim;
        int          n;
        bit          done;
        lim = int'(view_iter_limit);
        if (lim == 0)
            lim = 1;
        if (lim > int'(MAX_ITER))
            lim = int'(MAX_ITER);
        cr = view_real_origin + longint'(col) * view_real_step;
        ci = view_imag_origin + longint'(row) * view_imag_step;
        zr = 0;
        zi = 0;
        n = 0;
        done = 0;
        while (!done) begin
            nr = ((zr * zr - zi * zi) >>> FRAC_W) + cr;
            ni = ((zr * zi) >>> (FRAC_W - 1)) + ci;
            n++;
            if (nr < Q_LO || nr > Q_HI || ni < Q_LO || ni > Q_HI) begin
                done = 1;
            end else begin
                zr = nr;
                zi = ni;
                mag = 64'(zr * zr) + 64'(zi * zi);
                if (mag >= FOUR_WIDE || n >= lim)
                    done = 1;
            end
        end
        return CNT_W'(n);
    endfunction

    task automatic plan_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                              input bit typed, input logic [CNT_W-1:0] want);
        plan_entry_t e;
        e.kind = ENTRY_PIXEL;
        e.addr = '0;
        e.data = '0;
        e.pix_col = col;
        e.pix_row = row;
        e.typed = typed;
        e.want = want;
        directed_plan.push_back(e);
    endtask

    task automatic plan_write(input logic [CFG_IDX_W-1:0] addr, input logic [31:0] data);
        plan_entry_t e;
        e.kind = ENTRY_WRITE;
        e.addr = addr;
        e.data = data;
        e.pix_col = '0;
        e.pix_row = '0;
        e.typed = 0;
        e.want = '0;
        directed_plan.push_back(e);
    endtask

    // Called at a falling edge; returns at a falling edge with s_tvalid still high.
    task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                              input bit typed, input logic [CNT_W-1:0] want);
        pixel_result_t r;
        while ($urandom_range(0, 99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {row, col};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        r.iterations = typed ? want : escape_count(col, row);
        r.column = col;
        r.row = row;
        pending_pixels.push_back(r);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] addr, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (addr)
            CFG_REAL_ORIGIN: view_real_origin = longint'($signed(data));
            CFG_IMAG_ORIGIN: view_imag_origin = longint'($signed(data));
            CFG_REAL_STEP:   view_real_step = longint'(data[STEP_W-1:0]);
            CFG_IMAG_STEP:   view_imag_step = longint'(data[STEP_W-1:0]);
            CFG_ITER_LIMIT:  view_iter_limit = data[CNT_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Pick a window around the set, or pure noise now and then.
    task automatic write_random_view(input logic [CNT_W-1:0] lim);
        int ro, io, rs, is;
        if ($urandom_range(0, 9) == 0) begin
            ro = $urandom();
            io = $urandom();
            rs = $urandom();
            is = $urandom();
        end else begin
            ro = $urandom_range(0, 805306368) - 671088640;
            io = $urandom_range(0, 805306368) - 402653184;
            rs = $urandom_range(0, 196608) | ($urandom_range(0, 1) << 31);
            is = $urandom_range(0, 196608) | ($urandom_range(0, 1) << 31);
        end
        cfg_write(CFG_REAL_ORIGIN, ro);
        cfg_write(CFG_IMAG_ORIGIN, io);
        cfg_write(CFG_REAL_STEP, rs);
        cfg_write(CFG_IMAG_STEP, is);
        cfg_write(CFG_ITER_LIMIT, ($urandom() & 32'hFFFF_E000) | 32'(lim));
        if ($urandom_range(0, 3) == 0)
            cfg_write(CFG_UNUSED_IDX, $urandom());
    endtask

    always @(posedge aclk) begin
        pixel_result_t exp_px;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected output word %h", m_tdata);
                mismatch_count++;
            end else begin
                exp_px = pending_pixels.pop_front();
                if (m_tdata[CNT_W-1:0] !== exp_px.iterations) begin
                    $error("iterations: expected %0d, got %0d",
                           exp_px.iterations, m_tdata[CNT_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[CNT_W +: COORD_W] !== exp_px.column) begin
                    $error("out_column: expected %0d, got %0d",
                           exp_px.column, m_tdata[CNT_W +: COORD_W]);
                    mismatch_count++;
                end
                if (m_tdata[CNT_W+COORD_W +: COORD_W] !== exp_px.row) begin
                    $error("out_row: expected %0d, got %0d",
                           exp_px.row, m_tdata[CNT_W+COORD_W +: COORD_W]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_outputs) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_outputs = 0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= sink_idle);
            end
        end
    end

    initial begin
        #100_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int n_items;
        int lim;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        view_real_origin = -64'sd536870912;
        view_imag_origin = -64'sd536870912;
        view_real_step = 262144;
        view_imag_step = 262144;
        view_iter_limit = 13'd256;

        plan_pixel(0, 0, 1, 1);
        plan_pixel(4095, 4095, 1, 1);
        plan_pixel(4095, 0, 1, 1);
        plan_pixel(0, 4095, 1, 1);
        plan_pixel(2048, 2048, 1, 256);
        plan_pixel(1024, 2048, 0, 0);
        plan_pixel(2560, 2048, 0, 0);
        plan_pixel(1700, 2700, 0, 0);
        plan_write(CFG_ITER_LIMIT, 32'h0000_0000);
        plan_pixel(2048, 2048, 1, 1);
        plan_write(CFG_ITER_LIMIT, 32'h0000_1FFF);
        plan_pixel(2048, 2048, 1, CNT_W'(MAX_ITER));
        plan_write(CFG_ITER_LIMIT, 32'h0000_1000);
        plan_pixel(1100, 2100, 0, 0);
        plan_write(CFG_REAL_ORIGIN, 32'h7FFF_FFFF);
        plan_write(CFG_REAL_STEP, 32'h7FFF_FFFF);
        plan_pixel(4095, 2048, 1, 1);
        plan_pixel(0, 2048, 1, 1);
        plan_write(CFG_REAL_ORIGIN, 32'h8000_0000);
        plan_write(CFG_REAL_STEP, 32'h0000_0000);
        plan_write(CFG_IMAG_ORIGIN, 32'h8000_0000);
        plan_write(CFG_IMAG_STEP, 32'hFFFF_FFFF);
        plan_pixel(4095, 4095, 1, 1);
        plan_pixel(0, 0, 1, 1);
        plan_write(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
        plan_write(CFG_ITER_LIMIT, 32'h0000_0010);
        plan_write(CFG_REAL_ORIGIN, 32'hE000_0000);
        plan_write(CFG_REAL_STEP, 32'h0004_0000);
        plan_write(CFG_IMAG_ORIGIN, 32'hE000_0000);
        plan_write(CFG_IMAG_STEP, 32'h0004_0000);
        plan_pixel(2048, 2048, 1, 16);
        plan_pixel(1500, 2300, 0, 0);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == ENTRY_WRITE) begin
                settle();
                cfg_write(directed_plan[i].addr, directed_plan[i].data);
            end else begin
                send_pixel(directed_plan[i].pix_col, directed_plan[i].pix_row,
                           directed_plan[i].typed, directed_plan[i].want);
            end
        end

        for (int phase = 0; phase < 16; phase++) begin
            settle();
            if (phase == 5) begin
                src_idle = 59;
                sink_idle = 15;
            end else if (phase == 10) begin
                src_idle = 0;
                sink_idle = 0;
            end
            if (phase == 6) begin
                lim = $urandom_range(4096, 8191);
                n_items = 8;
            end else if (phase == 11) begin
                lim = 256;
                n_items = 80;
            end else begin
                lim = $urandom_range(0, 48);
                n_items = 110;
            end
            write_random_view(CNT_W'(lim));
            if (phase == 2)
                hold_outputs = 1;
            for (int k = 0; k < n_items; k++)
                send_pixel(COORD_W'($urandom_range(0, 4095)),
                           COORD_W'($urandom_range(0, 4095)), 0, 0);
        end

        settle();
        repeat (50) @(negedge aclk);
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mandel_pkg.sv
hw/rtl/mandel_front.sv
hw/rtl/mandel_fifo.sv
hw/rtl/mandel_core.sv
hw/rtl/mandelbrot_escape_iterations_top.sv
tb/tb.sv
